// ----- design/text_terminal_cell_writer_core_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the text terminal cell writer
// Each macro expects clk and rst in scope at the point of use.
// ---------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_CELL_WRITER_CORE_ASSERT_SVH
`define TEXT_TERMINAL_CELL_WRITER_CORE_ASSERT_SVH

// Check a condition at every rising clock edge outside reset
`define TTCW_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies another in the same cycle
`define TTCW_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Check that a condition implies another in the following cycle
`define TTCW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/ttcw_pkg.sv -----
// ---------------------------------------------------------------------------
// ttcw_pkg
// Shared types and constants for the text terminal cell writer.
// ---------------------------------------------------------------------------
package ttcw_pkg;

  // Default screen geometry
  localparam int COLUMNS_DEFAULT = 80;
  localparam int ROWS_DEFAULT    = 25;

  // Control characters
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_BLANK     = 8'd32;

  // Operation codes on the input channel
  localparam logic OP_CHAR    = 1'b0;
  localparam logic OP_SET_POS = 1'b1;

  // Configuration register indexes
  localparam int         CFG_INDEX_W        = 1;
  localparam logic [0:0] REG_TEXT_COLOR     = 1'd0;
  localparam logic [0:0] REG_DISPLAY_ENABLE = 1'd1;
  localparam logic [7:0] TEXT_COLOR_RESET   = 8'd7;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Port field widths
  localparam int CHAR_W    = 8;
  localparam int COL_IN_W  = 7;
  localparam int ROW_IN_W  = 5;
  localparam int ADDR_W    = 11;
  localparam int VALUE_W   = 16;

  typedef enum logic [2:0] {
    KIND_PRINT,
    KIND_NEWLINE,
    KIND_RETURN,
    KIND_BACKSPACE,
    KIND_SET_POS
  } kind_t;

  // One classified request
  typedef struct packed {
    kind_t                kind;
    logic [CHAR_W-1:0]    char_code;
    logic [COL_IN_W-1:0]  new_column;
    logic [ROW_IN_W-1:0]  new_row;
  } entry_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [7:0] text_color;
    logic       display_enable;
  } cfg_t;

endpackage

// ----- design/ttcw_front.sv -----
// ---------------------------------------------------------------------------
// ttcw_front
// Classifies an incoming request into a command kind for the back end.
// ---------------------------------------------------------------------------
module ttcw_front (
  input  logic                          op,
  input  logic [ttcw_pkg::CHAR_W-1:0]   char_code,
  input  logic [ttcw_pkg::COL_IN_W-1:0] new_column,
  input  logic [ttcw_pkg::ROW_IN_W-1:0] new_row,
  output ttcw_pkg::entry_t              entry
);
  import ttcw_pkg::*;

  kind_t kind;

  // Decode the command kind
  always_comb begin
    if (op == OP_SET_POS) begin
      kind = KIND_SET_POS;
    end else begin
      unique case (char_code)
        CH_NEWLINE:   kind = KIND_NEWLINE;
        CH_RETURN:    kind = KIND_RETURN;
        CH_BACKSPACE: kind = KIND_BACKSPACE;
        default:      kind = KIND_PRINT;
      endcase
    end
  end

  // Pack the request for the queue
  assign entry.kind       = kind;
  assign entry.char_code  = char_code;
  assign entry.new_column = new_column;
  assign entry.new_row    = new_row;

endmodule

// ----- design/ttcw_queue.sv -----
// ---------------------------------------------------------------------------
// ttcw_queue
// Short request queue that decouples the front from the back end.
// ---------------------------------------------------------------------------
`include "text_terminal_cell_writer_core_assert.svh"

module ttcw_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  ttcw_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop_ready,
  output ttcw_pkg::entry_t pop_entry
);
  import ttcw_pkg::*;

  localparam int PW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);

  entry_t          slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = (count != CNTW'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNTW'(1);
      end else if (pop && !push) begin
        count <= count - CNTW'(1);
      end
    end
  end

  // Hold request payloads
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  `TTCW_ASSERT_ALWAYS(a_count_range, count <= CNTW'(QUEUE_DEPTH), "queue overfilled")
  `TTCW_ASSERT_NEXT(a_count_up, push && !pop, count == $past(count) + CNTW'(1), "count lost a push")
  `TTCW_ASSERT_NEXT(a_count_down, pop && !push, count == $past(count) - CNTW'(1), "count lost a pop")

endmodule

// ----- design/ttcw_back.sv -----
// ---------------------------------------------------------------------------
// ttcw_back
// Carries out queued requests: moves the cursor and forms the cell write.
// ---------------------------------------------------------------------------
`include "text_terminal_cell_writer_core_assert.svh"

module ttcw_back #(
  parameter int COLUMNS = ttcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = ttcw_pkg::ROWS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  ttcw_pkg::cfg_t                cfg,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  ttcw_pkg::entry_t              req,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          write_valid,
  output logic [ttcw_pkg::ADDR_W-1:0]   cell_address,
  output logic [ttcw_pkg::VALUE_W-1:0]  cell_value,
  output logic [ttcw_pkg::COL_IN_W-1:0] cursor_column,
  output logic [ttcw_pkg::ROW_IN_W-1:0] cursor_row
);
  import ttcw_pkg::*;

  localparam int CW       = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CELLS    = COLUMNS * ROWS;
  localparam int AW       = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_IN_N = 2 ** COL_IN_W;
  localparam int ROW_IN_N = 2 ** ROW_IN_W;

  logic [CW-1:0]     column_position;
  logic [RW-1:0]     row_position;
  logic [CW-1:0]     column_next;
  logic [RW-1:0]     row_next;
  logic [CW-1:0]     column_mod [COL_IN_N];
  logic [RW-1:0]     row_mod [ROW_IN_N];
  logic [RW-1:0]     row_inc;
  logic [CW-1:0]     column_write;
  logic [CHAR_W-1:0] char_write;
  logic              cell_write;
  logic [AW-1:0]     address_full;
  logic              take;

  // Remainder tables for set position
  for (genvar g = 0; g < COL_IN_N; g++) begin : g_column_mod
    assign column_mod[g] = CW'(g % COLUMNS);
  end
  for (genvar g = 0; g < ROW_IN_N; g++) begin : g_row_mod
    assign row_mod[g] = RW'(g % ROWS);
  end

  assign row_inc = (row_position == RW'(ROWS - 1)) ? '0 : row_position + RW'(1);

  // Work out the cursor move and the cell to write
  always_comb begin
    column_next  = column_position;
    row_next     = row_position;
    column_write = column_position;
    char_write   = req.char_code;
    cell_write   = 1'b0;
    unique case (req.kind)
      KIND_SET_POS: begin
        column_next = column_mod[req.new_column];
        row_next    = row_mod[req.new_row];
      end
      KIND_NEWLINE: begin
        column_next = '0;
        row_next    = row_inc;
      end
      KIND_RETURN: begin
        column_next = '0;
      end
      KIND_BACKSPACE: begin
        column_next  = (column_position == '0) ? CW'(COLUMNS - 1)
                                               : column_position - CW'(1);
        column_write = column_next;
        char_write   = CH_BLANK;
        cell_write   = 1'b1;
      end
      KIND_PRINT: begin
        cell_write = 1'b1;
        if (column_position == CW'(COLUMNS - 1)) begin
          column_next = '0;
          row_next    = row_inc;
        end else begin
          column_next = column_position + CW'(1);
        end
      end
      default: begin
        cell_write = 1'b0;
      end
    endcase
  end

  assign address_full = AW'(row_position) * AW'(COLUMNS) + AW'(column_write);

  // Pop the queue whenever the result register is free or draining
  assign req_ready = !out_valid || out_ready;
  assign take      = req_valid && req_ready;

  // Hold cursor and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      column_position <= '0;
      row_position    <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (take) begin
        column_position <= column_next;
        row_position    <= row_next;
        out_valid       <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (take) begin
      write_valid   <= cell_write && cfg.display_enable;
      cell_address  <= (cell_write && cfg.display_enable) ? ADDR_W'(address_full) : '0;
      cell_value    <= (cell_write && cfg.display_enable) ? {cfg.text_color, char_write}
                                                          : '0;
      cursor_column <= COL_IN_W'(column_next);
      cursor_row    <= ROW_IN_W'(row_next);
    end
  end

  `TTCW_ASSERT_ALWAYS(a_column_range, 32'(column_position) < COLUMNS, "column out of range")
  `TTCW_ASSERT_ALWAYS(a_row_range, 32'(row_position) < ROWS, "row out of range")
  `TTCW_ASSERT_SAME(a_write_enabled, out_valid && write_valid, cfg.display_enable, "write while disabled")
  `TTCW_ASSERT_NEXT(a_take_result, take, out_valid, "popped request gave no result")

endmodule

// ----- design/text_terminal_cell_writer_core.sv -----
// ---------------------------------------------------------------------------
// text_terminal_cell_writer_core
// Cursor-tracking text terminal writer: one character or set-position
// request in, one result (optional cell write and cursor report) out.
// ---------------------------------------------------------------------------
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------------
//  in       | in_valid / in_ready   | op, char_code, new_column, new_row
//  out      | out_valid / out_ready | write_valid, cell_address, cell_value,
//           |                       | cursor_column, cursor_row
//  cfg      | cfg_write             | cfg_index, cfg_data
//
//  One request per cycle sustained while out_ready stays high; the
//  accepting edge loads a queue slot, and the result register is loaded
//  from the slot when the back end takes it, once a held result drains.
//  The cursor update in the back end is combinational logic, with one
//  small constant multiply for the cell address.
//  A two-entry queue lets input keep flowing while a result waits on out_ready.
//  Reset is synchronous; no clearing pass is needed.
// ---------------------------------------------------------------------------
module text_terminal_cell_writer_core #(
  parameter int COLUMNS = ttcw_pkg::COLUMNS_DEFAULT,
  parameter int ROWS    = ttcw_pkg::ROWS_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [ttcw_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                       cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             op,
  input  logic [ttcw_pkg::CHAR_W-1:0]      char_code,
  input  logic [ttcw_pkg::COL_IN_W-1:0]    new_column,
  input  logic [ttcw_pkg::ROW_IN_W-1:0]    new_row,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             write_valid,
  output logic [ttcw_pkg::ADDR_W-1:0]      cell_address,
  output logic [ttcw_pkg::VALUE_W-1:0]     cell_value,
  output logic [ttcw_pkg::COL_IN_W-1:0]    cursor_column,
  output logic [ttcw_pkg::ROW_IN_W-1:0]    cursor_row
);
  import ttcw_pkg::*;

  cfg_t   cfg;
  entry_t front_entry;
  entry_t queue_entry;
  logic   queue_valid;
  logic   queue_ready;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_color     <= TEXT_COLOR_RESET;
      cfg.display_enable <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_TEXT_COLOR:     cfg.text_color     <= cfg_data;
        REG_DISPLAY_ENABLE: cfg.display_enable <= cfg_data[0];
        default:            cfg.display_enable <= cfg.display_enable;
      endcase
    end
  end

  // Classify requests
  ttcw_front u_front (
    .op         (op),
    .char_code  (char_code),
    .new_column (new_column),
    .new_row    (new_row),
    .entry      (front_entry)
  );

  // Decouple front and back
  ttcw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_entry (front_entry),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_entry  (queue_entry)
  );

  // Execute requests
  ttcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .req_valid     (queue_valid),
    .req_ready     (queue_ready),
    .req           (queue_entry),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .write_valid   (write_valid),
    .cell_address  (cell_address),
    .cell_value    (cell_value),
    .cursor_column (cursor_column),
    .cursor_row    (cursor_row)
  );

endmodule

// ----- sim/tb.sv -----
// ---------------------------------------------------------------------------
// tb: text terminal cell writer testbench
// Drives character and set-position requests into the cell writer under
// changing colour and enable settings, tracks the cursor in a predictor of
// its own, and checks every reported cell write and cursor position in order.
// Both channels idle at random in phases.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ttcw_pkg::*;

  localparam int SCREEN_COLS    = COLUMNS_DEFAULT;
  localparam int SCREEN_ROWS    = ROWS_DEFAULT;
  localparam int STALL_LIMIT    = 2000;
  localparam int ITEMS_PER_PASS = 170;
  localparam int RANDOM_PASSES  = 8;
  localparam int PRINT_LIMIT    = 100;

  typedef struct packed {
    logic                op;
    logic [CHAR_W-1:0]   char_code;
    logic [COL_IN_W-1:0] new_column;
    logic [ROW_IN_W-1:0] new_row;
  } terminal_req_t;

  typedef struct packed {
    logic                write_valid;
    logic [ADDR_W-1:0]   cell_address;
    logic [VALUE_W-1:0]  cell_value;
    logic [COL_IN_W-1:0] cursor_column;
    logic [ROW_IN_W-1:0] cursor_row;
  } cell_report_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic                   op = OP_CHAR;
  logic [CHAR_W-1:0]      char_code = '0;
  logic [COL_IN_W-1:0]    new_column = '0;
  logic [ROW_IN_W-1:0]    new_row = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic                   write_valid;
  logic [ADDR_W-1:0]      cell_address;
  logic [VALUE_W-1:0]     cell_value;
  logic [COL_IN_W-1:0]    cursor_column;
  logic [ROW_IN_W-1:0]    cursor_row;

  text_terminal_cell_writer_core #(
    .COLUMNS(SCREEN_COLS),
    .ROWS   (SCREEN_ROWS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .char_code    (char_code),
    .new_column   (new_column),
    .new_row      (new_row),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_valid  (write_valid),
    .cell_address (cell_address),
    .cell_value   (cell_value),
    .cursor_column(cursor_column),
    .cursor_row   (cursor_row)
  );

  // Request and result bookkeeping
  terminal_req_t pending_requests[$];
  cell_report_t  awaited_cells[$];
  int            requests_queued = 0;
  int            requests_taken = 0;
  int            mismatch_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  logic          in_fire = 1'b0;
  int            quiet_cycles = 0;

  // Predictor state and its copy of the registers
  int         col_now = 0;
  int         row_now = 0;
  logic [7:0] attr_byte = TEXT_COLOR_RESET;
  logic       cells_enabled = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic note_mismatch(input string field, input int got, input int want);
    if (mismatch_count < PRINT_LIMIT)
      $display("tb: mismatch on %s at %0t: got %0d, want %0d", field, $realtime, got, want);
    mismatch_count++;
  endtask

  // Move the cursor for one request and work out the cell write it reports
  function automatic cell_report_t predict_cell_write(terminal_req_t req);
    cell_report_t res;
    logic         hits_cell;
    logic [7:0]   glyph;
    int           addr;
    res       = '0;
    hits_cell = 1'b0;
    glyph     = CH_BLANK;
    addr      = 0;
    if (req.op == OP_SET_POS) begin
      col_now = int'(req.new_column) % SCREEN_COLS;
      row_now = int'(req.new_row) % SCREEN_ROWS;
    end else if (req.char_code == CH_NEWLINE) begin
      col_now = 0;
      row_now = (row_now + 1) % SCREEN_ROWS;
    end else if (req.char_code == CH_RETURN) begin
      col_now = 0;
    end else if (req.char_code == CH_BACKSPACE) begin
      // step back, wrapping to the last column of the same row, then blank
      col_now   = (col_now == 0) ? SCREEN_COLS - 1 : col_now - 1;
      hits_cell = 1'b1;
      addr      = row_now * SCREEN_COLS + col_now;
    end else begin
      hits_cell = 1'b1;
      addr      = row_now * SCREEN_COLS + col_now;
      glyph     = req.char_code;
      col_now++;
      if (col_now >= SCREEN_COLS) begin
        col_now = 0;
        row_now = (row_now + 1) % SCREEN_ROWS;
      end
    end
    if (hits_cell && cells_enabled) begin
      res.write_valid  = 1'b1;
      res.cell_address = addr[ADDR_W-1:0];
      res.cell_value   = {attr_byte, glyph};
    end
    res.cursor_column = col_now[COL_IN_W-1:0];
    res.cursor_row    = row_now[ROW_IN_W-1:0];
    return res;
  endfunction

  function automatic void queue_char(input logic [7:0] code);
    terminal_req_t req;
    req.op         = OP_CHAR;
    req.char_code  = code;
    req.new_column = COL_IN_W'($urandom);
    req.new_row    = ROW_IN_W'($urandom);
    pending_requests.push_back(req);
    requests_queued++;
  endfunction

  function automatic void queue_set_pos(input int col, input int row);
    terminal_req_t req;
    req.op         = OP_SET_POS;
    req.char_code  = CHAR_W'($urandom);
    req.new_column = COL_IN_W'(col);
    req.new_row    = ROW_IN_W'(row);
    pending_requests.push_back(req);
    requests_queued++;
  endfunction

  // Mostly random characters, with control characters and cursor jumps mixed in
  function automatic void queue_random_request();
    int pick;
    int shape;
    pick  = $urandom_range(99);
    shape = $urandom_range(3);
    if (pick < 9) begin
      case (shape)
        0: queue_set_pos($urandom_range(SCREEN_COLS - 1), $urandom_range(SCREEN_ROWS - 1));
        1: queue_set_pos($urandom_range(SCREEN_COLS - 1, SCREEN_COLS - 3), SCREEN_ROWS - 1);
        2: queue_set_pos($urandom_range(SCREEN_COLS - 1, SCREEN_COLS - 4),
                         $urandom_range(SCREEN_ROWS - 1));
        default: queue_set_pos($urandom_range(127), $urandom_range(31));
      endcase
    end else if (pick < 15) begin
      queue_char(CH_NEWLINE);
    end else if (pick < 20) begin
      queue_char(CH_RETURN);
    end else if (pick < 28) begin
      queue_char(CH_BACKSPACE);
    end else begin
      queue_char(8'($urandom));
    end
  endfunction

  // Write one register at the falling edge and mirror it in the predictor
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_TEXT_COLOR:     attr_byte = data;
      REG_DISPLAY_ENABLE: cells_enabled = data[0];
      default: ;
    endcase
  endtask

  // Hold until every queued request is taken and every result has arrived
  task automatic wait_drained();
    do @(negedge clk);
    while (requests_taken != requests_queued || awaited_cells.size() != 0);
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 7; recv_stall_pct = 7; end
    endcase
  endtask

  // Stimulus: directed corners, then random passes under varied settings
  initial begin
    logic [7:0] colour;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings: display off, so nothing is written but the cursor moves
    set_idling(0);
    queue_char(8'h41);
    queue_char(CH_BACKSPACE);
    queue_char(CH_NEWLINE);
    queue_char(8'h7E);
    wait_drained();

    write_register(REG_TEXT_COLOR, 8'hFF);
    write_register(REG_DISPLAY_ENABLE, 8'h01);
    queue_set_pos(0, 0);
    queue_char(8'h00);
    queue_char(8'hFF);
    queue_char(8'h41);
    // last column wraps to the next row; last cell wraps to the top
    queue_set_pos(SCREEN_COLS - 1, 0);
    queue_char(8'h78);
    queue_set_pos(SCREEN_COLS - 1, SCREEN_ROWS - 1);
    queue_char(8'h5A);
    // backspace at column zero wraps to the end of the row
    queue_set_pos(0, 5);
    queue_char(CH_BACKSPACE);
    queue_char(CH_BACKSPACE);
    queue_char(CH_RETURN);
    queue_char(CH_NEWLINE);
    queue_set_pos(40, SCREEN_ROWS - 1);
    queue_char(CH_NEWLINE);
    // out-of-range positions fold back onto the screen
    queue_set_pos(127, 31);
    queue_char(8'h30);
    queue_set_pos(SCREEN_COLS, SCREEN_ROWS);
    queue_set_pos(SCREEN_COLS - 1, SCREEN_ROWS - 1);
    queue_char(CH_BACKSPACE);
    wait_drained();

    for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
      colour = (pass == 1) ? 8'h00 : (pass == 2) ? 8'hFF : 8'($urandom);
      write_register(REG_TEXT_COLOR, colour);
      write_register(REG_DISPLAY_ENABLE, {7'($urandom), (pass % 4 != 3)});
      set_idling(pass % 4);
      for (int n = 0; n < ITEMS_PER_PASS; n++)
        queue_random_request();
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (awaited_cells.size() != 0)
      note_mismatch("results outstanding", 0, awaited_cells.size());
    if (mismatch_count == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  // Driver: present the next request at the falling edge, idling at random
  always @(negedge clk) begin : drive_requests
    terminal_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_requests.pop_front();
        op         <= nxt.op;
        char_code  <= nxt.char_code;
        new_column <= nxt.new_column;
        new_row    <= nxt.new_row;
        in_valid   <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Monitor: check results against the oldest prediction, predict new requests
  always @(posedge clk) begin : watch_channels
    cell_report_t got;
    cell_report_t want;
    terminal_req_t req;
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && out_valid && out_ready) begin
      got = {write_valid, cell_address, cell_value, cursor_column, cursor_row};
      if (awaited_cells.size() == 0) begin
        note_mismatch("unexpected result", 1, 0);
      end else begin
        want = awaited_cells.pop_front();
        if (got.write_valid !== want.write_valid)
          note_mismatch("write_valid", got.write_valid, want.write_valid);
        if (got.cell_address !== want.cell_address)
          note_mismatch("cell_address", got.cell_address, want.cell_address);
        if (got.cell_value !== want.cell_value)
          note_mismatch("cell_value", got.cell_value, want.cell_value);
        if (got.cursor_column !== want.cursor_column)
          note_mismatch("cursor_column", got.cursor_column, want.cursor_column);
        if (got.cursor_row !== want.cursor_row)
          note_mismatch("cursor_row", got.cursor_row, want.cursor_row);
      end
    end
    if (!rst && in_valid && in_ready) begin
      req = {op, char_code, new_column, new_row};
      awaited_cells.push_back(predict_cell_write(req));
      requests_taken++;
    end
  end

  // Watchdog: end the run when neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
